[rtl/core/mkdbr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mkdbr_pkg;

  // Key count and field widths
  localparam int NUM_KEYS   = 7;
  localparam int DEB_W      = 4;
  localparam int REP_W      = 8;
  localparam int CFG_DATA_W = (NUM_KEYS > REP_W) ? NUM_KEYS : REP_W;
  localparam int CFG_IDX_W  = 2;

  // Reset values of the configuration registers
  localparam logic [DEB_W-1:0]    DEBOUNCE_TICKS_RST     = DEB_W'(3);
  localparam logic [REP_W-1:0]    REPEAT_TICKS_RST       = REP_W'(50);
  localparam logic [NUM_KEYS-1:0] PRESS_ENABLE_MASK_RST  = NUM_KEYS'(15);
  localparam logic [NUM_KEYS-1:0] REPEAT_ENABLE_MASK_RST = NUM_KEYS'(1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS     = 2'd0,
    REG_REPEAT_TICKS       = 2'd1,
    REG_PRESS_ENABLE_MASK  = 2'd2,
    REG_REPEAT_ENABLE_MASK = 2'd3
  } cfg_reg_t;

  // Timing settings shared by every lane
  typedef struct packed {
    logic [DEB_W-1:0] debounce_ticks;
    logic [REP_W-1:0] repeat_ticks;
  } lane_cfg_t;

  // What one lane reports for one tick
  typedef struct packed {
    logic press;
    logic rpt;
    logic level;
  } lane_res_t;

endpackage

`default_nettype wire

[rtl/core/mkdbr_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module mkdbr_lane (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic                  raw_bit,
  input  wire mkdbr_pkg::lane_cfg_t  cfg,
  input  wire logic                  press_en,
  input  wire logic                  repeat_en,
  output mkdbr_pkg::lane_res_t       res
);

  logic                           stable_r, stable_nxt;
  logic [mkdbr_pkg::DEB_W-1:0]    dcnt_r, dcnt_nxt;
  logic [mkdbr_pkg::REP_W-1:0]    hold_r, hold_nxt;
  logic [mkdbr_pkg::DEB_W:0]      dcnt_inc;
  logic [mkdbr_pkg::REP_W:0]      hold_inc;
  logic                           deb_hit;
  logic                           rep_hit;

  assign dcnt_inc = {1'b0, dcnt_r} + {{mkdbr_pkg::DEB_W{1'b0}}, 1'b1};
  assign hold_inc = {1'b0, hold_r} + {{mkdbr_pkg::REP_W{1'b0}}, 1'b1};
  assign deb_hit  = dcnt_inc >= {1'b0, cfg.debounce_ticks};
  assign rep_hit  = hold_inc >= {1'b0, cfg.repeat_ticks};

  // Debounce and hold-repeat rules for one tick
  always_comb begin
    stable_nxt = stable_r;
    dcnt_nxt   = dcnt_r;
    hold_nxt   = hold_r;
    res        = '0;
    if (raw_bit != stable_r) begin
      if (deb_hit) begin
        stable_nxt = raw_bit;
        dcnt_nxt   = '0;
        if (!raw_bit) begin
          hold_nxt  = '0;
          res.press = press_en;
        end
      end else begin
        dcnt_nxt = dcnt_inc[mkdbr_pkg::DEB_W-1:0];
      end
    end else begin
      dcnt_nxt = '0;
      if (!stable_r) begin
        if (rep_hit) begin
          hold_nxt = '0;
          res.rpt  = repeat_en;
        end else begin
          hold_nxt = hold_inc[mkdbr_pkg::REP_W-1:0];
        end
      end
    end
    res.level = stable_nxt;
  end

  // Advance key state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      dcnt_r   <= '0;
      hold_r   <= '0;
    end else if (accept) begin
      stable_r <= stable_nxt;
      dcnt_r   <= dcnt_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/mkdbr_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module mkdbr_merge (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  output logic                                    accept,
  input  wire mkdbr_pkg::lane_res_t               lane_res [mkdbr_pkg::NUM_KEYS],
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [mkdbr_pkg::NUM_KEYS-1:0]          out_press_events,
  output logic [mkdbr_pkg::NUM_KEYS-1:0]          out_repeat_events,
  output logic [mkdbr_pkg::NUM_KEYS-1:0]          out_stable_levels
);

  localparam int N = mkdbr_pkg::NUM_KEYS;

  logic [N-1:0] press_vec, rpt_vec, level_vec;
  logic         out_valid_r, skid_valid_r;
  logic [N-1:0] out_press_r, out_rpt_r, out_level_r;
  logic [N-1:0] skid_press_r, skid_rpt_r, skid_level_r;
  logic         out_take;

  // Gather lane bits into result vectors
  always_comb begin
    for (int k = 0; k < N; k++) begin
      press_vec[k] = lane_res[k].press;
      rpt_vec[k]   = lane_res[k].rpt;
      level_vec[k] = lane_res[k].level;
    end
  end

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  // Output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload moves, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_press_r <= skid_press_r;
        out_rpt_r   <= skid_rpt_r;
        out_level_r <= skid_level_r;
      end
    end else if (accept) begin
      if (!out_valid_r || out_take) begin
        out_press_r <= press_vec;
        out_rpt_r   <= rpt_vec;
        out_level_r <= level_vec;
      end else begin
        skid_press_r <= press_vec;
        skid_rpt_r   <= rpt_vec;
        skid_level_r <= level_vec;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_press_events  = out_press_r;
  assign out_repeat_events = out_rpt_r;
  assign out_stable_levels = out_level_r;

  // Skid holds data only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  // An accepted transaction always lands somewhere
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction lost");

  // Skid drains into the output register when the result is taken
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_take) |=> (out_valid_r && !skid_valid_r))
    else $error("skid stage failed to drain");

  // A stalled full pipe keeps both entries
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_take) |=> (skid_valid_r && out_valid_r))
    else $error("pending result dropped");

endmodule

`default_nettype wire

[rtl/core/multi_key_debounce_with_repeat_top.sv]
// Channel   Ports                                                  Direction
// input     in_valid, in_stall, in_raw_levels                      tick sample in
// result    out_valid, out_stall, out_press_events,
//           out_repeat_events, out_stable_levels                   events out
// config    cfg_we, cfg_index, cfg_wdata                           register write
//
// One transaction per cycle while in_stall is low; each result is registered in
// the output register, or in the skid stage while the output stalls. Seven key
// lanes update in parallel on each accepted sample; an output register plus a
// one-entry skid stage keep input accepted while a result waits. in_stall rises
// only when both the output register and the skid are full. Synchronous
// active-low reset: all keys stably pressed, counters cleared, registers at their defaults.
`timescale 1ns / 1ps
`default_nettype none

module multi_key_debounce_with_repeat_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [mkdbr_pkg::NUM_KEYS-1:0]        in_raw_levels,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [mkdbr_pkg::NUM_KEYS-1:0]             out_press_events,
  output logic [mkdbr_pkg::NUM_KEYS-1:0]             out_repeat_events,
  output logic [mkdbr_pkg::NUM_KEYS-1:0]             out_stable_levels,
  input  wire logic                                  cfg_we,
  input  wire logic [mkdbr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mkdbr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int N = mkdbr_pkg::NUM_KEYS;

  mkdbr_pkg::lane_cfg_t  lane_cfg_r;
  logic [N-1:0]          press_en_r;
  logic [N-1:0]          repeat_en_r;
  mkdbr_pkg::lane_res_t  lane_res [N];
  logic                  accept;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_cfg_r.debounce_ticks <= mkdbr_pkg::DEBOUNCE_TICKS_RST;
      lane_cfg_r.repeat_ticks   <= mkdbr_pkg::REPEAT_TICKS_RST;
      press_en_r                <= mkdbr_pkg::PRESS_ENABLE_MASK_RST;
      repeat_en_r               <= mkdbr_pkg::REPEAT_ENABLE_MASK_RST;
    end else if (cfg_we) begin
      unique case (mkdbr_pkg::cfg_reg_t'(cfg_index))
        mkdbr_pkg::REG_DEBOUNCE_TICKS:
          lane_cfg_r.debounce_ticks <= cfg_wdata[mkdbr_pkg::DEB_W-1:0];
        mkdbr_pkg::REG_REPEAT_TICKS:
          lane_cfg_r.repeat_ticks <= cfg_wdata[mkdbr_pkg::REP_W-1:0];
        mkdbr_pkg::REG_PRESS_ENABLE_MASK:
          press_en_r <= cfg_wdata[N-1:0];
        mkdbr_pkg::REG_REPEAT_ENABLE_MASK:
          repeat_en_r <= cfg_wdata[N-1:0];
        default: ;
      endcase
    end
  end

  // One lane per key
  for (genvar k = 0; k < N; k++) begin : g_lane
    mkdbr_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .accept    (accept),
      .raw_bit   (in_raw_levels[k]),
      .cfg       (lane_cfg_r),
      .press_en  (press_en_r[k]),
      .repeat_en (repeat_en_r[k]),
      .res       (lane_res[k])
    );
  end

  // Merge lane results and buffer toward the result channel
  mkdbr_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .accept            (accept),
    .lane_res          (lane_res),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_press_events  (out_press_events),
    .out_repeat_events (out_repeat_events),
    .out_stable_levels (out_stable_levels)
  );

endmodule

`default_nettype wire
